>>> hw/rtl/assert_macros.svh
// Assertion helpers included by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define TTI_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked while out of reset.
`define TTI_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/tti_pkg.sv
`timescale 1ns / 1ps
package tti_pkg;

	localparam int ADC_W      = 16;
	localparam int TEMP_W     = 16;
	localparam int STEP_W     = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int STATUS_W   = 2;
	localparam int PROD_W     = STEP_W + ADC_W;
	localparam int SUM_W      = PROD_W + 2;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_CONVERT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_START    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_STEP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLAGGING = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_IN_RANGE = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BELOW    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ABOVE    = 2'd2;

	localparam logic signed [SUM_W-1:0]  SUM_MAX  = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0]  SUM_MIN  = SUM_W'(-32768);
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK_LAST,
		S_CHK_FIRST,
		S_SEARCH,
		S_LO,
		S_HI,
		S_MUL,
		S_DIV_GO,
		S_DIV_WAIT,
		S_POINT,
		S_SUM
	} tti_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> hw/rtl/tti_divider.sv
`timescale 1ns / 1ps
module tti_divider #(
	parameter int DEN_W = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tti_pkg::STEP_W+DEN_W:0]  numer,
	input  logic [DEN_W-1:0]                denom,
	output logic [tti_pkg::STEP_W-1:0]      quotient,
	output tti_pkg::div_stat_t              stat
);
	import tti_pkg::*;

	localparam int CNT_W = $clog2(STEP_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEP_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [STEP_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W+2:0] cat;
	logic [DEN_W+2:0] trial;
	logic             ge;

	// Quotient is known to fit STEP_W bits, so the top of the numerator
	// already sits below the divisor and only STEP_W bits need resolving.
	always_comb begin
		cat   = {1'b0, rem_q, quo_q[STEP_W-1]};
		trial = cat - (DEN_W + 3)'(den_q);
		ge    = !trial[DEN_W+2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer[STEP_W+DEN_W:STEP_W];
			quo_q <= numer[STEP_W-1:0];
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DEN_W:0] : cat[DEN_W:0];
			quo_q <= {quo_q[STEP_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> hw/rtl/thermistor_table_interpolator_unit.sv
`timescale 1ns / 1ps
// Thermistor table interpolator: turns an ADC reading into a temperature using a descending
// table of TABLE_DEPTH readings, entry i standing for table_start + i * table_step. A load item
// (kind 0) writes one entry and gives no result; every entry must be loaded before the first
// conversion. A convert item (kind 1) clamps readings beyond either end of the table to the end
// temperature (reported in status when range_flagging is set), otherwise binary-searches the
// bracketing pair and interpolates with a rounded division. Input ready is low while a
// conversion runs. The last entry is checked before the first. Interpolation does one table
// read per search step and runs a ten-step restoring divider. A result waits in an output
// register; new items are taken meanwhile, but a following conversion holds in S_SUM until
// the register is free.
`include "assert_macros.svh"

module thermistor_table_interpolator_unit #(
	parameter int TABLE_DEPTH = 32,
	parameter int ENTRY_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              kind,
	input  logic [4:0]                        entry_index,
	input  logic [tti_pkg::ADC_W-1:0]         adc_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [tti_pkg::TEMP_W-1:0] temperature,
	output logic [tti_pkg::STATUS_W-1:0]      status,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tti_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tti_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tti_pkg::*;

	localparam int IW    = $clog2(TABLE_DEPTH);
	localparam int NUM_W = STEP_W + ENTRY_WIDTH + 1;
	localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_DEPTH - 1);
	localparam logic [IW-1:0] IDX_MID0 = IW'((TABLE_DEPTH - 1) / 2);

	// configuration
	logic signed [TEMP_W-1:0] table_start_q;
	logic [STEP_W-1:0]        table_step_q;
	logic                     range_flagging_q;

	// control
	tti_state_t state_q, state_d;
	logic       out_valid_q;
	logic       in_fire;
	logic       mem_we;
	logic [IW-1:0] rd_addr;
	logic       div_start;
	logic       load_result;

	// table store
	logic [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [ENTRY_WIDTH-1:0] rd_data_q;
	logic [IW-1:0]          addr_q;

	// datapath
	logic [ADC_W-1:0]       adc_q;
	logic [IW-1:0]          lo_q, hi_q, pidx_q;
	logic [STATUS_W-1:0]    pend_status_q;
	logic [ENTRY_WIDTH-1:0] vl_q, diff_q, vd_q;
	logic [PROD_W-1:0]      prod_q;
	logic [STEP_W-1:0]      quo_q;
	logic signed [TEMP_W-1:0] temperature_q;
	logic [STATUS_W-1:0]    res_status_q;

	logic [ADC_W-1:0]  ent;
	logic              adc_gt, adc_lt;
	logic [IW-1:0]     nlo, nhi, nmid;
	logic [IW:0]       mid_sum;
	logic              span_more;
	logic [ADC_W-1:0]  mul_b;
	logic [NUM_W-1:0]  div_num;
	logic [STEP_W-1:0] div_quo;
	div_stat_t         div_stat;
	logic signed [SUM_W-1:0]  sum_s;
	logic signed [TEMP_W-1:0] temp_sat;

	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_start_q    <= '0;
			table_step_q     <= STEP_W'(10);
			range_flagging_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TABLE_START:    table_start_q    <= signed'(cfg_data[TEMP_W-1:0]);
				REG_TABLE_STEP:     table_step_q     <= cfg_data[STEP_W-1:0];
				REG_RANGE_FLAGGING: range_flagging_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- table store
	assign mem_we = in_fire && (kind == KIND_LOAD)
		&& ({27'b0, entry_index} < 32'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[IW'(entry_index)] <= adc_value[ENTRY_WIDTH-1:0];
		end
		rd_data_q <= mem[rd_addr];
		addr_q    <= rd_addr;
	end

	// ---------------------------------------------------------------- compare and search step
	always_comb begin
		ent       = ADC_W'(rd_data_q);
		adc_gt    = adc_q > ent;
		adc_lt    = adc_q < ent;
		nlo       = adc_gt ? lo_q : addr_q;
		nhi       = adc_gt ? addr_q : hi_q;
		mid_sum   = {1'b0, nlo} + {1'b0, nhi};
		nmid      = mid_sum[IW:1];
		span_more = (nhi - nlo) > IW'(1);
	end

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:      if (in_fire && kind == KIND_CONVERT) state_d = S_CHK_LAST;
			S_CHK_LAST:  state_d = adc_gt ? S_CHK_FIRST : S_POINT;
			S_CHK_FIRST: begin
				if (!adc_lt)              state_d = S_POINT;
				else if (TABLE_DEPTH > 2) state_d = S_SEARCH;
				else                      state_d = S_LO;
			end
			S_SEARCH:    state_d = span_more ? S_SEARCH : S_LO;
			S_LO:        state_d = adc_lt ? S_HI : S_POINT;
			S_HI:        state_d = (vl_q > rd_data_q) ? S_MUL : S_POINT;
			S_MUL:       state_d = S_DIV_GO;
			S_DIV_GO:    state_d = S_DIV_WAIT;
			S_DIV_WAIT:  if (div_stat.done) state_d = S_POINT;
			S_POINT:     state_d = S_SUM;
			S_SUM:       if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- control outputs
	always_comb begin
		in_ready    = 1'b0;
		rd_addr     = IDX_LAST;
		div_start   = 1'b0;
		load_result = 1'b0;
		unique case (state_q)
			S_IDLE:      in_ready = 1'b1;
			S_CHK_LAST:  rd_addr = '0;
			S_CHK_FIRST: rd_addr = IDX_MID0;
			S_SEARCH:    rd_addr = span_more ? nmid : nlo;
			S_LO:        rd_addr = hi_q;
			S_DIV_GO:    div_start = 1'b1;
			S_SUM:       load_result = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_result)    out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- datapath
	assign mul_b   = (state_q == S_MUL) ? ADC_W'(diff_q) : ADC_W'(pidx_q);
	assign div_num = NUM_W'(prod_q[STEP_W+ENTRY_WIDTH-1:0]) + NUM_W'(vd_q >> 1);

	always_comb begin
		sum_s = SUM_W'(table_start_q) + signed'({2'b00, prod_q}) - signed'(SUM_W'(quo_q));
		if (sum_s > SUM_MAX)      temp_sat = TEMP_MAX;
		else if (sum_s < SUM_MIN) temp_sat = TEMP_MIN;
		else                      temp_sat = sum_s[TEMP_W-1:0];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					adc_q         <= adc_value;
					quo_q         <= '0;
					pend_status_q <= STATUS_IN_RANGE;
				end
			end
			S_CHK_LAST: begin
				pidx_q <= IDX_LAST;
				if (range_flagging_q && adc_lt) pend_status_q <= STATUS_BELOW;
			end
			S_CHK_FIRST: begin
				pidx_q <= '0;
				lo_q   <= '0;
				hi_q   <= IDX_LAST;
				if (range_flagging_q && adc_gt) pend_status_q <= STATUS_ABOVE;
			end
			S_SEARCH: begin
				lo_q <= nlo;
				hi_q <= nhi;
			end
			S_LO: begin
				vl_q   <= rd_data_q;
				pidx_q <= lo_q;
			end
			S_HI: begin
				pidx_q <= hi_q;
				diff_q <= ENTRY_WIDTH'(adc_q - ent);
				vd_q   <= vl_q - rd_data_q;
			end
			S_MUL:      prod_q <= PROD_W'(table_step_q * mul_b);
			S_DIV_WAIT: if (div_stat.done) quo_q <= div_quo;
			S_POINT:    prod_q <= PROD_W'(table_step_q * mul_b);
			default: ;
		endcase
		if (load_result) begin
			temperature_q <= temp_sat;
			res_status_q  <= pend_status_q;
		end
	end

	tti_divider #(
		.DEN_W (ENTRY_WIDTH)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_num),
		.denom    (vd_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	assign out_valid   = out_valid_q;
	assign temperature = temperature_q;
	assign status      = res_status_q;

	// ---------------------------------------------------------------- checks
	`TTI_ASSERT_IMP(a_bracket_open, clk, arst_n, state_q == S_SEARCH, hi_q > lo_q + 1)
	`TTI_ASSERT_IMP(a_div_start_ok, clk, arst_n, div_start, vd_q != '0 && !div_stat.busy)
	`TTI_ASSERT_IMP(a_quo_bound, clk, arst_n, div_stat.done, div_quo <= table_step_q)
	`TTI_ASSERT_IMP(a_no_clobber, clk, arst_n, out_valid_q && !out_ready, !load_result)
	`TTI_ASSERT_NXT(a_result_shown, clk, arst_n, load_result, out_valid_q)

endmodule

>>> test/tb_thermistor_table_interpolator_unit.sv
`timescale 1ns / 1ps
module tb_thermistor_table_interpolator_unit;
	import tti_pkg::*;

	localparam int DEPTH      = 32;
	localparam int IDLE_WAIT  = 40;
	localparam int END_WAIT   = 60;
	localparam int DRAIN_MAX  = 20000;
	localparam int RX_ALWAYS  = 0;
	localparam int RX_HALF    = 1;
	localparam int RX_SPARSE  = 2;
	localparam int RX_STALL   = 3;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic [STATUS_W-1:0]      status;
	} conv_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    kind = KIND_LOAD;
	logic [4:0]              entry_index = '0;
	logic [ADC_W-1:0]        adc_value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [TEMP_W-1:0] temperature;
	logic [STATUS_W-1:0]     status;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	// Shadow of the block: table contents and register settings
	logic [ADC_W-1:0]         table_copy [DEPTH];
	logic [ADC_W-1:0]         table_plan [DEPTH];
	logic signed [TEMP_W-1:0] cur_start = '0;
	logic [STEP_W-1:0]        cur_step = 10'd10;
	logic                     cur_flagging = 1'b0;

	conv_result_t pending_conversions[$];
	conv_result_t expected_head;
	int errors = 0;
	int burst_left = 0;
	int rx_mode = RX_ALWAYS;
	int rx_count = 0;

	thermistor_table_interpolator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.entry_index(entry_index),
		.adc_value(adc_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.temperature(temperature),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic longint entry_temperature(input int idx);
		longint s;
		longint st;
		s = cur_start;
		st = cur_step;
		return s + longint'(idx) * st;
	endfunction

	function automatic conv_result_t interpolate_temperature(input logic [ADC_W-1:0] reading);
		conv_result_t r;
		int lo;
		int hi;
		int mid;
		longint a;
		longint vl;
		longint vr;
		longint vd;
		longint temp;
		longint st;
		a = reading;
		lo = 0;
		hi = DEPTH - 1;
		st = cur_step;
		r.status = STATUS_IN_RANGE;
		if (reading <= table_copy[hi]) begin
			temp = entry_temperature(hi);
			if (cur_flagging && reading < table_copy[hi])
				r.status = STATUS_BELOW;
		end else if (reading >= table_copy[0]) begin
			temp = cur_start;
			if (cur_flagging && reading > table_copy[0])
				r.status = STATUS_ABOVE;
		end else begin
			while (hi - lo > 1) begin
				mid = (lo + hi) >> 1;
				if (reading > table_copy[mid])
					hi = mid;
				else
					lo = mid;
			end
			vl = table_copy[lo];
			vr = table_copy[hi];
			if (a >= vl) begin
				temp = entry_temperature(lo);
			end else begin
				temp = entry_temperature(hi);
				if (vl > vr) begin
					vd = vl - vr;
					temp = temp - (st * (a - vr) + (vd >> 1)) / vd;
				end
			end
		end
		if (temp > 32767)
			r.temperature = TEMP_MAX;
		else if (temp < -32768)
			r.temperature = TEMP_MIN;
		else
			r.temperature = temp[TEMP_W-1:0];
		return r;
	endfunction

	// Receiver: changes its stall habit at random intervals
	always @(posedge clk) begin
		if (rx_count == 0) begin
			rx_mode <= $urandom_range(RX_ALWAYS, RX_STALL);
			rx_count <= $urandom_range(20, 80);
		end else begin
			rx_count <= rx_count - 1;
		end
		case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= (rx_count < 4);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_conversions.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected: temperature %0d status %0d",
					$time, temperature, status);
			end else begin
				expected_head = pending_conversions.pop_front();
				if (temperature !== expected_head.temperature) begin
					errors++;
					$display("%0t: temperature expected %0d actual %0d",
						$time, expected_head.temperature, temperature);
				end
				if (status !== expected_head.status) begin
					errors++;
					$display("%0t: status expected %0d actual %0d",
						$time, expected_head.status, status);
				end
			end
		end
	end

	// Sender pacing: bursts of random length, random gaps in between
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_item(input logic k, input logic [4:0] idx,
		input logic [ADC_W-1:0] value);
		pace_sender();
		in_valid <= 1'b1;
		kind <= k;
		entry_index <= idx;
		adc_value <= value;
		do @(posedge clk); while (!in_ready);
		if (k == KIND_LOAD)
			table_copy[idx] = value;
		else
			pending_conversions.push_back(interpolate_temperature(value));
	endtask

	task automatic convert(input logic [ADC_W-1:0] value);
		send_item(KIND_CONVERT, 5'd0, value);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_conversions.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TABLE_START:    cur_start = data;
			REG_TABLE_STEP:     cur_step = data[STEP_W-1:0];
			REG_RANGE_FLAGGING: cur_flagging = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic signed [TEMP_W-1:0] start,
		input int step, input logic flag);
		hold_until_drained();
		repeat (IDLE_WAIT) @(posedge clk);
		write_register(REG_TABLE_START, start);
		write_register(REG_TABLE_STEP, CFG_DATA_W'(step));
		write_register(REG_RANGE_FLAGGING, {15'd0, flag});
	endtask

	// Load every entry of table_plan, in a shuffled order
	task automatic load_table_plan();
		int order [DEPTH];
		int j;
		int t;
		for (int i = 0; i < DEPTH; i++)
			order[i] = i;
		for (int i = DEPTH - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < DEPTH; i++)
			send_item(KIND_LOAD, 5'(order[i]), table_plan[order[i]]);
	endtask

	task automatic plan_descending_table(input int max_drop);
		int v;
		int drop;
		v = $urandom_range(30000, 65535);
		for (int i = 0; i < DEPTH; i++) begin
			table_plan[i] = ADC_W'(v);
			drop = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, max_drop);
			v = (v > drop) ? v - drop : 0;
		end
	endtask

	function automatic logic [ADC_W-1:0] pick_reading();
		int sel;
		int i;
		int v;
		sel = $urandom_range(0, 99);
		i = $urandom_range(0, DEPTH - 2);
		if (sel < 55) begin
			v = $urandom_range(table_copy[i], table_copy[i + 1]);
		end else if (sel < 70) begin
			v = table_copy[$urandom_range(0, DEPTH - 1)];
		end else if (sel < 80) begin
			if ($urandom_range(0, 1))
				v = (table_copy[0] == 16'hFFFF) ? 65535 : table_copy[0] + 1;
			else
				v = (table_copy[DEPTH - 1] == 16'h0000) ? 0 : table_copy[DEPTH - 1] - 1;
		end else if (sel < 88) begin
			v = $urandom_range(0, 1) ? 65535 : 0;
		end else begin
			v = $urandom_range(0, 65535);
		end
		return ADC_W'(v);
	endfunction

	task automatic run_random_items(input int count, input bit pause_midway);
		for (int n = 0; n < count; n++) begin
			if (pause_midway && n == count / 2)
				hold_until_drained();
			if ($urandom_range(0, 99) < 12)
				send_item(KIND_LOAD, 5'($urandom_range(0, DEPTH - 1)),
					ADC_W'($urandom_range(0, 65535)));
			else
				convert(pick_reading());
		end
	endtask

	task automatic test_reset_defaults();
		for (int i = 0; i < DEPTH; i++)
			table_plan[i] = ADC_W'(65535 - i * 2000);
		load_table_plan();
		convert(16'h0000);
		convert(16'hFFFF);
		convert(table_plan[DEPTH - 1]);
		convert(16'd40001);
	endtask

	task automatic test_range_flags();
		set_config(16'sd250, 37, 1'b1);
		for (int i = 0; i < DEPTH; i++)
			table_plan[i] = ADC_W'(60000 - i * 1900);
		// equal neighbours in the middle of the table
		table_plan[11] = table_plan[10];
		load_table_plan();
		convert(16'hFFFF);
		convert(16'd60001);
		convert(16'd60000);
		convert(16'h0000);
		convert(table_plan[DEPTH - 1]);
		convert(table_plan[DEPTH - 1] - 16'd1);
		convert(table_plan[7]);
		convert(table_plan[10]);
		convert(table_plan[12] + 16'd5);
		convert(table_plan[20] - 16'd1);
	endtask

	task automatic test_register_extremes();
		set_config(-16'sd32768, 1000, 1'b1);
		convert(16'h0000);
		convert(16'hFFFF);
		convert(table_plan[3] - 16'd950);
		set_config(16'sd32767, 1000, 1'b0);
		convert(16'h0000);
		convert(16'hFFFF);
		convert(table_plan[15] - 16'd3);
		set_config(-16'sd1234, 0, 1'b1);
		convert(table_plan[25] + 16'd100);
		convert(16'h0000);
	endtask

	task automatic test_random_tables();
		logic signed [TEMP_W-1:0] start;
		int step;
		int max_drop;
		for (int phase = 0; phase < 5; phase++) begin
			case ($urandom_range(0, 3))
				0: start = -16'sd32768;
				1: start = 16'sd32767;
				default: start = TEMP_W'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 3))
				0: step = 0;
				1: step = 1000;
				default: step = $urandom_range(0, 1000);
			endcase
			set_config(start, step, 1'($urandom_range(0, 1)));
			case ($urandom_range(0, 2))
				0: max_drop = 4;
				1: max_drop = 300;
				default: max_drop = 2000;
			endcase
			plan_descending_table(max_drop);
			load_table_plan();
			run_random_items(40, phase == 2);
		end
	endtask

	task automatic test_non_descending();
		set_config(TEMP_W'($urandom_range(0, 65535)), $urandom_range(0, 1000),
			1'($urandom_range(0, 1)));
		for (int i = 0; i < DEPTH; i++)
			table_plan[i] = ADC_W'($urandom_range(0, 65535));
		load_table_plan();
		run_random_items(60, 1'b1);
	endtask

	initial begin
		int waited;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_range_flags();
		test_register_extremes();
		test_random_tables();
		test_non_descending();
		in_valid <= 1'b0;
		waited = 0;
		while (pending_conversions.size() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		repeat (END_WAIT) @(posedge clk);
		if (pending_conversions.size() != 0) begin
			errors++;
			$display("%0t: %0d conversions never delivered", $time,
				pending_conversions.size());
		end
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> thermistor_table_interpolator_unit.f
+incdir+hw/rtl
hw/rtl/tti_pkg.sv
hw/rtl/tti_divider.sv
hw/rtl/thermistor_table_interpolator_unit.sv
test/tb_thermistor_table_interpolator_unit.sv
